[hw/rtl/rfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types, codes and fixed-point helpers of the reflection frustum block.
// ----------------------------------------------------------------------------
package rfp_pkg;

   localparam int REG_CENTER = 0;
   localparam int REG_RIGHT  = 1;
   localparam int REG_FRONT  = 2;
   localparam int REG_UP     = 3;
   localparam int NUM_REGS   = 4;
   localparam int REG_W      = 63;
   localparam int COMP_W     = 21;
   localparam int QDEPTH     = 2;
   localparam int LAST_STEP  = 8;

   typedef enum logic [2:0] {
      KIND_REFL   = 3'd0,
      KIND_FOOT   = 3'd1,
      KIND_NEAR   = 3'd2,
      KIND_FAR    = 3'd3,
      KIND_LEFT   = 3'd4,
      KIND_RIGHT  = 3'd5,
      KIND_BOTTOM = 3'd6,
      KIND_TOP    = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      VEC_UP    = 2'd0,
      VEC_RIGHT = 2'd1,
      VEC_FRONT = 2'd2
   } vec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_DIVIDE,
      ST_FINISH
   } setup_state_type;

   typedef struct packed {
      logic busy;
      logic degenerate;
   } setup_stat_type;

   // round to nearest, ties away from zero; negative shift is a left shift
   function automatic logic signed [95:0] rnd_shr(input logic signed [95:0] a,
                                                  input int sh);
      logic [95:0] mag;
      logic [95:0] res;
      logic signed [95:0] outv;
      mag = a[95] ? 96'(-a) : 96'(a);
      if (sh <= 0) begin
         outv = a <<< (-sh);
      end else begin
         res  = (mag + (96'd1 << (sh - 1))) >> sh;
         outv = a[95] ? -$signed(res) : $signed(res);
      end
      return outv;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [95:0] v);
      logic [31:0] r;
      if (v > 96'sh7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -96'sh8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/rfp_setup.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfp_setup
// Surface registers and the normaliser: bit-serial square root and divider
// turn up, -right and front into unit vectors after every register change.
// ----------------------------------------------------------------------------
module rfp_setup #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wen,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [rfp_pkg::REG_W-1:0]     csr_wdata,
   output rfp_pkg::setup_stat_type            stat,
   output logic signed [FRAC_BITS+2:0]        n_vec   [3],
   output logic signed [FRAC_BITS+2:0]        m_vec   [3],
   output logic signed [FRAC_BITS+2:0]        k_vec   [3],
   output logic signed [FRAC_BITS+23:0]       ctr_q   [3],
   output logic signed [FRAC_BITS+23:0]       cr1_q   [3],
   output logic signed [FRAC_BITS+23:0]       cr2_q   [3],
   output logic signed [FRAC_BITS+23:0]       cf1_q   [3],
   output logic signed [FRAC_BITS+23:0]       cf2_q   [3]
);

   localparam int AW   = FRAC_BITS + 24;
   localparam int NW   = FRAC_BITS + 3;
   localparam int DVW  = FRAC_BITS + 33;
   localparam int CNTW = $clog2(DVW + 1);

   logic [rfp_pkg::REG_W-1:0]       regs_ff [rfp_pkg::NUM_REGS];
   logic                            dirty_ff;
   rfp_pkg::setup_state_type        state_ff, state_in;
   rfp_pkg::vec_type                vec_ff;
   logic [1:0]                      comp_ff;
   logic [CNTW-1:0]                 cnt_ff;
   logic [40:0]                     sq_ff   [3];
   logic [61:0]                     rad_ff;
   logic [34:0]                     rem_ff;
   logic [31:0]                     root_ff;
   logic [DVW-1:0]                  dvd_ff;
   logic [31:0]                     drem_ff;
   logic signed [NW-1:0]            norm_ff [3][3];
   logic                            deg_ff;
   logic signed [AW-1:0]            ctr_ff [3], cr1_ff [3], cr2_ff [3], cf1_ff [3], cf2_ff [3];

   logic [rfp_pkg::REG_W-1:0]       vreg;
   logic signed [21:0]              raw [3];
   logic [21:0]                     mag;
   logic [41:0]                     sum_sq;
   logic [34:0]                     rem_next, trial;
   logic [32:0]                     dtry;
   logic signed [AW-1:0]            cq [3], rq [3], fq [3];

   always_comb begin
      case (vec_ff)
         rfp_pkg::VEC_UP:    vreg = regs_ff[rfp_pkg::REG_UP];
         rfp_pkg::VEC_RIGHT: vreg = regs_ff[rfp_pkg::REG_RIGHT];
         rfp_pkg::VEC_FRONT: vreg = regs_ff[rfp_pkg::REG_FRONT];
         default:            vreg = regs_ff[rfp_pkg::REG_UP];
      endcase
      for (int k = 0; k < 3; k++) begin
         raw[k] = 22'($signed(vreg[rfp_pkg::COMP_W*k +: rfp_pkg::COMP_W]));
         if (vec_ff == rfp_pkg::VEC_RIGHT) begin
            raw[k] = -raw[k];
         end
         cq[k] = AW'(rfp_pkg::rnd_shr(96'($signed(
                 regs_ff[rfp_pkg::REG_CENTER][rfp_pkg::COMP_W*k +: rfp_pkg::COMP_W])) <<< FRAC_BITS,
                 10));
         rq[k] = AW'(rfp_pkg::rnd_shr(96'($signed(
                 regs_ff[rfp_pkg::REG_RIGHT][rfp_pkg::COMP_W*k +: rfp_pkg::COMP_W])) <<< FRAC_BITS,
                 10));
         fq[k] = AW'(rfp_pkg::rnd_shr(96'($signed(
                 regs_ff[rfp_pkg::REG_FRONT][rfp_pkg::COMP_W*k +: rfp_pkg::COMP_W])) <<< FRAC_BITS,
                 10));
      end
      mag      = raw[comp_ff][21] ? 22'(-raw[comp_ff]) : 22'(raw[comp_ff]);
      sum_sq   = 42'(sq_ff[0]) + 42'(sq_ff[1]) + 42'(sq_ff[2]);
      rem_next = {rem_ff[32:0], rad_ff[61:60]};
      trial    = {1'b0, root_ff, 2'b01};
      dtry     = {drem_ff, dvd_ff[DVW-1]};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rfp_pkg::ST_IDLE:   if (dirty_ff) state_in = rfp_pkg::ST_SQUARE;
         rfp_pkg::ST_SQUARE: state_in = rfp_pkg::ST_SUM;
         rfp_pkg::ST_SUM: begin
            if (sum_sq != '0) begin
               state_in = rfp_pkg::ST_ROOT;
            end else if (vec_ff == rfp_pkg::VEC_FRONT) begin
               state_in = rfp_pkg::ST_FINISH;
            end else begin
               state_in = rfp_pkg::ST_SQUARE;
            end
         end
         rfp_pkg::ST_ROOT:   if (cnt_ff == '0) state_in = rfp_pkg::ST_DIVIDE;
         rfp_pkg::ST_DIVIDE: begin
            if (cnt_ff == '0 && comp_ff == 2'd2) begin
               state_in = (vec_ff == rfp_pkg::VEC_FRONT) ? rfp_pkg::ST_FINISH
                                                         : rfp_pkg::ST_SQUARE;
            end
         end
         rfp_pkg::ST_FINISH: state_in = rfp_pkg::ST_IDLE;
         default:            state_in = rfp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < rfp_pkg::NUM_REGS; r++) begin
            regs_ff[r] <= '0;
         end
         dirty_ff <= 1'b1;
         deg_ff   <= 1'b0;
         vec_ff   <= rfp_pkg::VEC_UP;
      end else begin
         if (csr_wen) begin
            regs_ff[csr_index] <= csr_wdata;
         end
         if (csr_wen) begin
            dirty_ff <= 1'b1;
         end else if (state_ff == rfp_pkg::ST_IDLE) begin
            dirty_ff <= 1'b0;
         end
         case (state_ff)
            rfp_pkg::ST_IDLE: begin
               vec_ff <= rfp_pkg::VEC_UP;
               if (dirty_ff) deg_ff <= 1'b0;
            end
            rfp_pkg::ST_SUM: begin
               if (sum_sq == '0) begin
                  deg_ff <= 1'b1;
                  if (vec_ff != rfp_pkg::VEC_FRONT) begin
                     vec_ff <= rfp_pkg::vec_type'(vec_ff + 2'd1);
                  end
               end
            end
            rfp_pkg::ST_DIVIDE: begin
               if (cnt_ff == '0 && comp_ff == 2'd2 && vec_ff != rfp_pkg::VEC_FRONT) begin
                  vec_ff <= rfp_pkg::vec_type'(vec_ff + 2'd1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         rfp_pkg::ST_SQUARE: begin
            for (int k = 0; k < 3; k++) sq_ff[k] <= 41'(raw[k]) * 41'(raw[k]);
         end
         rfp_pkg::ST_SUM: begin
            if (sum_sq == '0) begin
               for (int k = 0; k < 3; k++) norm_ff[vec_ff][k] <= '0;
            end
            rad_ff  <= {sum_sq, 20'd0};
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= CNTW'(31);
         end
         rfp_pkg::ST_ROOT: begin
            if (cnt_ff != '0) begin
               rad_ff <= {rad_ff[59:0], 2'b00};
               cnt_ff <= cnt_ff - 1'b1;
               if (rem_next >= trial) begin
                  rem_ff  <= rem_next - trial;
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff  <= rem_next;
                  root_ff <= {root_ff[30:0], 1'b0};
               end
            end else begin
               comp_ff <= 2'd0;
               drem_ff <= '0;
               cnt_ff  <= CNTW'(DVW);
               dvd_ff  <= DVW'({raw[0][21] ? 22'(-raw[0]) : 22'(raw[0]),
                                {(FRAC_BITS + 10){1'b0}}}) + DVW'(root_ff >> 1);
            end
         end
         rfp_pkg::ST_DIVIDE: begin
            if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - 1'b1;
               if (dtry >= {1'b0, root_ff}) begin
                  drem_ff <= 32'(dtry - {1'b0, root_ff});
                  dvd_ff  <= {dvd_ff[DVW-2:0], 1'b1};
               end else begin
                  drem_ff <= dtry[31:0];
                  dvd_ff  <= {dvd_ff[DVW-2:0], 1'b0};
               end
            end else begin
               norm_ff[vec_ff][comp_ff] <= raw[comp_ff][21] ? NW'(-$signed({1'b0, dvd_ff}))
                                                            : NW'($signed({1'b0, dvd_ff}));
               if (comp_ff != 2'd2) begin
                  comp_ff <= comp_ff + 2'd1;
                  drem_ff <= '0;
                  cnt_ff  <= CNTW'(DVW);
                  dvd_ff  <= DVW'({raw[comp_ff + 2'd1][21] ? 22'(-raw[comp_ff + 2'd1])
                                                          : 22'(raw[comp_ff + 2'd1]),
                                   {(FRAC_BITS + 10){1'b0}}}) + DVW'(root_ff >> 1);
               end
            end
         end
         rfp_pkg::ST_FINISH: begin
            for (int k = 0; k < 3; k++) begin
               ctr_ff[k] <= cq[k];
               cr1_ff[k] <= cq[k] + rq[k];
               cr2_ff[k] <= cq[k] - rq[k];
               cf1_ff[k] <= cq[k] - fq[k];
               cf2_ff[k] <= cq[k] + fq[k];
            end
         end
         default: ;
      endcase
   end

   assign stat.busy       = dirty_ff || (state_ff != rfp_pkg::ST_IDLE);
   assign stat.degenerate = deg_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         n_vec[k] = norm_ff[rfp_pkg::VEC_UP][k];
         m_vec[k] = norm_ff[rfp_pkg::VEC_RIGHT][k];
         k_vec[k] = norm_ff[rfp_pkg::VEC_FRONT][k];
         ctr_q[k] = ctr_ff[k];
         cr1_q[k] = cr1_ff[k];
         cr2_q[k] = cr2_ff[k];
         cf1_q[k] = cf1_ff[k];
         cf2_q[k] = cf2_ff[k];
      end
   end

   unused_mag_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfp_pkg::ST_DIVIDE) |-> (mag[21] == 1'b0 || mag == 22'h20_0000))
      else $error("component magnitude out of range");

   root_before_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfp_pkg::ST_DIVIDE) |-> (root_ff != '0))
      else $error("divide started with zero length");

   write_rearms: assert property (@(posedge clock) disable iff (reset)
      csr_wen |=> stat.busy)
      else $error("register write did not restart the normaliser");

endmodule
`default_nettype wire

[hw/rtl/rfp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfp_front
// Takes eye beats, forms the offset from the surface centre and holds both
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rfp_front #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [95:0]                   req_tdata,
   input  wire rfp_pkg::setup_stat_type       stat,
   input  wire logic signed [FRAC_BITS+23:0]  ctr_q   [3],
   output logic                               head_valid,
   input  wire logic                          head_pop,
   output logic signed [31:0]                 head_eye [3],
   output logic signed [FRAC_BITS+23:0]       head_d   [3]
);

   localparam int AW = FRAC_BITS + 24;
   localparam int PW = $clog2(rfp_pkg::QDEPTH);
   localparam int CW = $clog2(rfp_pkg::QDEPTH + 1);

   logic signed [31:0]    eye_ff [rfp_pkg::QDEPTH][3];
   logic signed [AW-1:0]  d_ff   [rfp_pkg::QDEPTH][3];
   logic [PW-1:0]         wr_ff, rd_ff;
   logic [CW-1:0]         cnt_ff;
   logic                  push;

   assign req_tready = !stat.busy && (cnt_ff != CW'(rfp_pkg::QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (cnt_ff != '0);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         head_eye[k] = eye_ff[rd_ff][k];
         head_d[k]   = d_ff[rd_ff][k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (head_pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + CW'(push) - CW'(head_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         for (int k = 0; k < 3; k++) begin
            eye_ff[wr_ff][k] <= $signed(req_tdata[32*k +: 32]);
            d_ff[wr_ff][k]   <= AW'($signed(req_tdata[32*k +: 32])) - ctr_q[k];
         end
      end
   end

   no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !push)
      else $error("beat taken during normalisation");

   fill_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(rfp_pkg::QDEPTH))
      else $error("queue overfilled");

   pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("pop from empty queue");

endmodule
`default_nettype wire

[hw/rtl/rfp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfp_back
// Nine-step sequencer over three multiplier lanes: distance to the surface,
// foot and mirrored eye, near distance, then the four side planes.
// ----------------------------------------------------------------------------
module rfp_back #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   output logic                               head_pop,
   input  wire logic signed [31:0]            head_eye [3],
   input  wire logic signed [FRAC_BITS+23:0]  head_d   [3],
   input  wire logic signed [FRAC_BITS+2:0]   n_vec    [3],
   input  wire logic signed [FRAC_BITS+2:0]   m_vec    [3],
   input  wire logic signed [FRAC_BITS+2:0]   k_vec    [3],
   input  wire logic signed [FRAC_BITS+23:0]  cr1_q    [3],
   input  wire logic signed [FRAC_BITS+23:0]  cr2_q    [3],
   input  wire logic signed [FRAC_BITS+23:0]  cf1_q    [3],
   input  wire logic signed [FRAC_BITS+23:0]  cf2_q    [3],
   output logic                               rec_valid,
   input  wire logic                          rec_ready,
   output logic signed [FRAC_BITS+23:0]       rec_refl [3],
   output logic signed [FRAC_BITS+23:0]       rec_foot [3],
   output logic signed [FRAC_BITS+23:0]       rec_near,
   output logic signed [FRAC_BITS+23:0]       rec_dist [4]
);

   localparam int AW = FRAC_BITS + 24;
   localparam int NW = FRAC_BITS + 3;
   localparam int PW = AW + NW;
   localparam int RW = AW - 9;
   localparam logic [RW-1:0] RECIP = RW'((64'd1 << AW) / 64'd1000);

   logic                  run_ff;
   logic [3:0]            step_ff;
   logic signed [31:0]    eye_ff [3];
   logic signed [AW-1:0]  d_ff   [3];
   logic signed [PW-1:0]  prod_ff [3];
   logic signed [AW-1:0]  t_ff;
   logic                  tneg_ff;
   logic [AW-1:0]         a_ff;
   logic [AW+RW-1:0]      rprod_ff;
   logic signed [AW-1:0]  foot_ff [3], refl_ff [3], near_ff;
   logic signed [AW-1:0]  dist_ff [3];

   logic signed [AW-1:0]  opa [3];
   logic signed [NW-1:0]  opb [3];
   logic signed [AW-1:0]  psum;
   logic signed [AW-1:0]  w   [3];
   logic [AW-1:0]         tabs;
   logic [RW-1:0]         q0;
   logic [AW:0]           remv;
   logic [RW-1:0]         quot;
   logic                  load;

   assign load     = head_valid && (!run_ff ||
                     (step_ff == 4'(rfp_pkg::LAST_STEP) && rec_ready));
   assign head_pop = load;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         case (step_ff)
            4'd2:    begin opa[k] = t_ff;                 opb[k] = n_vec[k]; end
            4'd4:    begin opa[k] = cr1_q[k] - foot_ff[k]; opb[k] = m_vec[k]; end
            4'd5:    begin opa[k] = cr2_q[k] - foot_ff[k]; opb[k] = m_vec[k]; end
            4'd6:    begin opa[k] = cf1_q[k] - foot_ff[k]; opb[k] = k_vec[k]; end
            4'd7:    begin opa[k] = cf2_q[k] - foot_ff[k]; opb[k] = k_vec[k]; end
            default: begin opa[k] = d_ff[k];              opb[k] = n_vec[k]; end
         endcase
         w[k] = AW'(rfp_pkg::rnd_shr(96'(prod_ff[k]), FRAC_BITS));
      end
      psum = AW'(rfp_pkg::rnd_shr(96'(prod_ff[0]), FRAC_BITS)
               + rfp_pkg::rnd_shr(96'(prod_ff[1]), FRAC_BITS)
               + rfp_pkg::rnd_shr(96'(prod_ff[2]), FRAC_BITS));
      tabs = t_ff[AW-1] ? AW'(-t_ff) : AW'(t_ff);
      q0   = rprod_ff[AW+RW-1:AW];
      remv = {1'b0, a_ff} - (AW+1)'(q0) * (AW+1)'(11'd1000);
      quot = (remv >= (AW+1)'(1000)) ? RW'(q0 + 1'b1) : q0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else if (load) begin
         run_ff  <= 1'b1;
         step_ff <= '0;
      end else if (run_ff && step_ff != 4'(rfp_pkg::LAST_STEP)) begin
         step_ff <= step_ff + 4'd1;
      end else if (run_ff && rec_ready) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < 3; k++) begin
            eye_ff[k] <= head_eye[k];
            d_ff[k]   <= head_d[k];
         end
      end
      if (step_ff != 4'(rfp_pkg::LAST_STEP)) begin
         for (int k = 0; k < 3; k++) prod_ff[k] <= PW'(opa[k]) * PW'(opb[k]);
      end
      case (step_ff)
         4'd1: t_ff <= psum;
         4'd2: begin
            tneg_ff  <= t_ff[AW-1];
            a_ff     <= tabs + AW'(500);
            rprod_ff <= (AW+RW)'(tabs + AW'(500)) * (AW+RW)'(RECIP);
         end
         4'd3: begin
            for (int k = 0; k < 3; k++) begin
               foot_ff[k] <= AW'(eye_ff[k]) - w[k];
               refl_ff[k] <= AW'(eye_ff[k]) - (w[k] <<< 1);
            end
            near_ff <= tneg_ff ? t_ff - AW'(quot) : t_ff + AW'(quot);
         end
         4'd5: dist_ff[0] <= psum;
         4'd6: dist_ff[1] <= psum;
         4'd7: dist_ff[2] <= psum;
         default: ;
      endcase
   end

   assign rec_valid = run_ff && (step_ff == 4'(rfp_pkg::LAST_STEP));

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rec_refl[k] = refl_ff[k];
         rec_foot[k] = foot_ff[k];
         rec_dist[k] = dist_ff[k];
      end
      rec_dist[3] = psum;
      rec_near    = near_ff;
   end

   step_bounded: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 4'(rfp_pkg::LAST_STEP))
      else $error("sequencer step out of range");

   hold_until_taken: assert property (@(posedge clock) disable iff (reset)
      (rec_valid && !rec_ready) |=> rec_valid)
      else $error("finished item dropped before hand-off");

endmodule
`default_nettype wire

[hw/rtl/rfp_emit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfp_emit
// Holds one finished item and plays it out as eight result beats through
// a registered output stage.
// ----------------------------------------------------------------------------
module rfp_emit #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rec_valid,
   output logic                               rec_ready,
   input  wire logic signed [FRAC_BITS+23:0]  rec_refl [3],
   input  wire logic signed [FRAC_BITS+23:0]  rec_foot [3],
   input  wire logic signed [FRAC_BITS+23:0]  rec_near,
   input  wire logic signed [FRAC_BITS+23:0]  rec_dist [4],
   input  wire logic signed [FRAC_BITS+2:0]   n_vec    [3],
   input  wire logic signed [FRAC_BITS+2:0]   m_vec    [3],
   input  wire logic signed [FRAC_BITS+2:0]   k_vec    [3],
   input  wire rfp_pkg::setup_stat_type       stat,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [135:0]                       rsp_tdata,
   output logic [2:0]                         rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int AW = FRAC_BITS + 24;

   logic                  buf_ff;
   logic [2:0]            beat_ff;
   logic signed [AW-1:0]  refl_ff [3], foot_ff [3], near_ff, dist_ff [4];
   logic                  out_ff;
   logic [2:0]            kind_ff;
   logic [31:0]           vx_ff, vy_ff, vz_ff, pd_ff;
   logic                  deg_ff;

   logic                  adv;
   logic signed [95:0]    v [3];
   logic signed [95:0]    pd;

   assign adv       = buf_ff && (!out_ff || rsp_tready);
   assign rec_ready = !buf_ff || (adv && beat_ff == 3'(rfp_pkg::KIND_TOP));

   always_comb begin
      case (rfp_pkg::kind_type'(beat_ff))
         rfp_pkg::KIND_REFL: begin
            for (int k = 0; k < 3; k++) v[k] = 96'(refl_ff[k]);
            pd = '0;
         end
         rfp_pkg::KIND_FOOT: begin
            for (int k = 0; k < 3; k++) v[k] = 96'(foot_ff[k]);
            pd = '0;
         end
         rfp_pkg::KIND_NEAR: begin
            for (int k = 0; k < 3; k++) v[k] = 96'(n_vec[k]);
            pd = 96'(near_ff);
         end
         rfp_pkg::KIND_FAR: begin
            for (int k = 0; k < 3; k++) v[k] = 96'(n_vec[k]);
            pd = 96'sh7FFF_FFFF;
         end
         rfp_pkg::KIND_LEFT: begin
            for (int k = 0; k < 3; k++) v[k] = -96'(m_vec[k]);
            pd = 96'(dist_ff[0]);
         end
         rfp_pkg::KIND_RIGHT: begin
            for (int k = 0; k < 3; k++) v[k] = 96'(m_vec[k]);
            pd = 96'(dist_ff[1]);
         end
         rfp_pkg::KIND_BOTTOM: begin
            for (int k = 0; k < 3; k++) v[k] = 96'(k_vec[k]);
            pd = 96'(dist_ff[2]);
         end
         default: begin
            for (int k = 0; k < 3; k++) v[k] = 96'(k_vec[k]);
            pd = 96'(dist_ff[3]);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff  <= 1'b0;
         beat_ff <= '0;
         out_ff  <= 1'b0;
      end else begin
         if (rec_valid && rec_ready) begin
            buf_ff <= 1'b1;
         end else if (adv && beat_ff == 3'(rfp_pkg::KIND_TOP)) begin
            buf_ff <= 1'b0;
         end
         if (adv) begin
            beat_ff <= beat_ff + 3'd1;
            out_ff  <= 1'b1;
         end else if (rsp_tready) begin
            out_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rec_valid && rec_ready) begin
         for (int k = 0; k < 3; k++) begin
            refl_ff[k] <= rec_refl[k];
            foot_ff[k] <= rec_foot[k];
         end
         for (int k = 0; k < 4; k++) dist_ff[k] <= rec_dist[k];
         near_ff <= rec_near;
      end
      if (adv) begin
         kind_ff <= beat_ff;
         vx_ff   <= rfp_pkg::sat32(v[0]);
         vy_ff   <= rfp_pkg::sat32(v[1]);
         vz_ff   <= rfp_pkg::sat32(v[2]);
         pd_ff   <= rfp_pkg::sat32(pd);
         deg_ff  <= stat.degenerate;
      end
   end

   assign rsp_tvalid = out_ff;
   assign rsp_tdata  = {7'd0, deg_ff, pd_ff, vz_ff, vy_ff, vx_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = (kind_ff == 3'(rfp_pkg::KIND_TOP));

   beats_need_item: assert property (@(posedge clock) disable iff (reset)
      (beat_ff != '0) |-> buf_ff)
      else $error("beat counter running without an item");

   no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rec_valid && rec_ready) |-> (!buf_ff || beat_ff == 3'(rfp_pkg::KIND_TOP)))
      else $error("item loaded over one still playing out");

endmodule
`default_nettype wire

[hw/rtl/reflection_frustum_planes.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reflection_frustum_planes
// Mirrored eye, foot point and six frustum planes of a rectangular reflecting
// surface for each eye position, in signed fixed point.
// ----------------------------------------------------------------------------
// The nine-step back sequencer on three shared multiplier lanes works on one
// eye beat at a time and loads the next as it hands its item on; each item
// gives 8 result beats.
// Reset: synchronous; the surface registers clear to zero and the normaliser
// then runs with req_tready low. Every register write reruns it the same way.
module reflection_frustum_planes #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [95:0]                req_tdata,   // eye_x, eye_y, eye_z
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [135:0]                    rsp_tdata,   // vec_x, vec_y, vec_z, plane_dist,
                                                        // degenerate, zero fill
   output logic [2:0]                      rsp_tuser,   // result_kind
   output logic                            rsp_tlast,
   input  wire logic                       csr_wen,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [rfp_pkg::REG_W-1:0]  csr_wdata
);

   localparam int AW = FRAC_BITS + 24;
   localparam int NW = FRAC_BITS + 3;

   rfp_pkg::setup_stat_type  stat;
   logic signed [NW-1:0]     n_vec [3], m_vec [3], k_vec [3];
   logic signed [AW-1:0]     ctr_q [3], cr1_q [3], cr2_q [3], cf1_q [3], cf2_q [3];
   logic                     head_valid, head_pop;
   logic signed [31:0]       head_eye [3];
   logic signed [AW-1:0]     head_d [3];
   logic                     rec_valid, rec_ready;
   logic signed [AW-1:0]     rec_refl [3], rec_foot [3], rec_near, rec_dist [4];

   rfp_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .n_vec     (n_vec),
      .m_vec     (m_vec),
      .k_vec     (k_vec),
      .ctr_q     (ctr_q),
      .cr1_q     (cr1_q),
      .cr2_q     (cr2_q),
      .cf1_q     (cf1_q),
      .cf2_q     (cf2_q)
   );

   rfp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .stat       (stat),
      .ctr_q      (ctr_q),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_eye   (head_eye),
      .head_d     (head_d)
   );

   rfp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_eye   (head_eye),
      .head_d     (head_d),
      .n_vec      (n_vec),
      .m_vec      (m_vec),
      .k_vec      (k_vec),
      .cr1_q      (cr1_q),
      .cr2_q      (cr2_q),
      .cf1_q      (cf1_q),
      .cf2_q      (cf2_q),
      .rec_valid  (rec_valid),
      .rec_ready  (rec_ready),
      .rec_refl   (rec_refl),
      .rec_foot   (rec_foot),
      .rec_near   (rec_near),
      .rec_dist   (rec_dist)
   );

   rfp_emit #(.FRAC_BITS(FRAC_BITS)) u_emit (
      .clock      (clock),
      .reset      (reset),
      .rec_valid  (rec_valid),
      .rec_ready  (rec_ready),
      .rec_refl   (rec_refl),
      .rec_foot   (rec_foot),
      .rec_near   (rec_near),
      .rec_dist   (rec_dist),
      .n_vec      (n_vec),
      .m_vec      (m_vec),
      .k_vec      (k_vec),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

[verif/reflection_frustum_planes_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reflection_frustum_planes_test
// Streams eye positions through the reflection frustum block under several
// surface settings and checks every result beat, in order, against a
// fixed-point prediction of the mirrored eye, the foot point and the six planes.
// ----------------------------------------------------------------------------
module reflection_frustum_planes_test;

   localparam int FRAC = 16;
   localparam longint ONE = longint'(1) << FRAC;

   typedef struct {
      rfp_pkg::kind_type kind;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] vz;
      logic [31:0] pdist;
      logic        deg;
      logic        last;
   } plane_beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wen = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [62:0]  csr_wdata = '0;

   logic [62:0]     surface [rfp_pkg::NUM_REGS];
   logic [95:0]     eye_queue [$];
   plane_beat_type  plane_queue [$];
   int           errors = 0;
   int           send_pct = 0;
   int           recv_pct = 0;
   bit           eye_taken = 0;
   bit           send_hold = 0;
   bit           stall_req = 0;
   int           stall_left = 0;

   reflection_frustum_planes #(.FRAC_BITS(FRAC)) dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint rdiv(longint a, longint b);
      if (a >= 0) return (a + b / 2) / b;
      return -((-a + b / 2) / b);
   endfunction

   function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned res = 0;
      longint unsigned bitv = longint'(1) << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint raw_comp(logic [62:0] r, int k);
      logic [20:0] c;
      c = r[21*k +: 21];
      return longint'($signed(c));
   endfunction

   function automatic bit unit_vec(input longint c [3], output longint u [3]);
      longint unsigned s = 0;
      longint len;
      for (int k = 0; k < 3; k++) s += longint'(c[k] * c[k]);
      if (s == 0) begin
         for (int k = 0; k < 3; k++) u[k] = 0;
         return 1'b1;
      end
      len = longint'(isqrt(s << 20));
      for (int k = 0; k < 3; k++) u[k] = rdiv(c[k] * ONE * 1024, len);
      return 1'b0;
   endfunction

   function automatic longint dot3(input longint a [3], input longint b [3]);
      longint s = 0;
      for (int k = 0; k < 3; k++) s += rdiv(a[k] * b[k], ONE);
      return s;
   endfunction

   function automatic logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic void push_plane(rfp_pkg::kind_type kind, input longint v [3],
                                      longint pdist, bit deg);
      plane_beat_type b;
      b.kind = kind;
      b.vx = clip32(v[0]);
      b.vy = clip32(v[1]);
      b.vz = clip32(v[2]);
      b.pdist = clip32(pdist);
      b.deg = deg;
      b.last = (kind == rfp_pkg::KIND_TOP);
      plane_queue.push_back(b);
   endfunction

   function automatic void predict_planes(logic [95:0] eye_bits);
      longint eye [3], raw [3], ctr [3], rgt [3], frt [3];
      longint n [3], m [3], kv [3], q [3], refl [3], d [3], neg [3];
      longint t, w;
      bit deg;
      for (int i = 0; i < 3; i++) begin
         eye[i] = longint'($signed(eye_bits[32*i +: 32]));
         ctr[i] = rdiv(raw_comp(surface[rfp_pkg::REG_CENTER], i) * ONE, 1024);
         rgt[i] = rdiv(raw_comp(surface[rfp_pkg::REG_RIGHT], i) * ONE, 1024);
         frt[i] = rdiv(raw_comp(surface[rfp_pkg::REG_FRONT], i) * ONE, 1024);
         raw[i] = -raw_comp(surface[rfp_pkg::REG_RIGHT], i);
      end
      deg = unit_vec(raw, m);
      for (int i = 0; i < 3; i++) raw[i] = raw_comp(surface[rfp_pkg::REG_FRONT], i);
      deg |= unit_vec(raw, kv);
      for (int i = 0; i < 3; i++) raw[i] = raw_comp(surface[rfp_pkg::REG_UP], i);
      deg |= unit_vec(raw, n);
      for (int i = 0; i < 3; i++) d[i] = eye[i] - ctr[i];
      t = dot3(d, n);
      for (int i = 0; i < 3; i++) begin
         w = rdiv(t * n[i], ONE);
         q[i] = eye[i] - w;
         refl[i] = eye[i] - 2 * w;
      end
      push_plane(rfp_pkg::KIND_REFL, refl, 0, deg);
      push_plane(rfp_pkg::KIND_FOOT, q, 0, deg);
      push_plane(rfp_pkg::KIND_NEAR, n, t + rdiv(t, 1000), deg);
      push_plane(rfp_pkg::KIND_FAR, n, 64'sd2147483647, deg);
      for (int i = 0; i < 3; i++) begin
         d[i] = ctr[i] + rgt[i] - q[i];
         neg[i] = -m[i];
      end
      push_plane(rfp_pkg::KIND_LEFT, neg, dot3(d, m), deg);
      for (int i = 0; i < 3; i++) d[i] = ctr[i] - rgt[i] - q[i];
      push_plane(rfp_pkg::KIND_RIGHT, m, dot3(d, m), deg);
      for (int i = 0; i < 3; i++) d[i] = ctr[i] - frt[i] - q[i];
      push_plane(rfp_pkg::KIND_BOTTOM, kv, dot3(d, kv), deg);
      for (int i = 0; i < 3; i++) d[i] = ctr[i] + frt[i] - q[i];
      push_plane(rfp_pkg::KIND_TOP, kv, dot3(d, kv), deg);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
      end
   endfunction

   // driver: advance to the next eye beat once the current one is taken
   always @(negedge clock) begin
      if (!req_tvalid || eye_taken) begin
         eye_taken = 0;
         if (!reset && !send_hold && eye_queue.size() > 0 &&
             $urandom_range(0, 99) >= send_pct) begin
            req_tdata  <= eye_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure, plus a long hold-off on request
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stall_req) begin
         stall_req = 0;
         stall_left = 300;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      plane_beat_type b;
      if (!reset && req_tvalid && req_tready) begin
         predict_planes(req_tdata);
         eye_taken = 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (plane_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat kind %0d", $realtime, rsp_tuser);
         end else begin
            b = plane_queue.pop_front();
            check_field("kind", 32'(b.kind), 32'(rsp_tuser));
            check_field("vec_x", b.vx, rsp_tdata[31:0]);
            check_field("vec_y", b.vy, rsp_tdata[63:32]);
            check_field("vec_z", b.vz, rsp_tdata[95:64]);
            check_field("plane_dist", b.pdist, rsp_tdata[127:96]);
            check_field("degenerate", 32'(b.deg), 32'(rsp_tdata[128]));
            check_field("last", 32'(b.last), 32'(rsp_tlast));
         end
      end
   end

   function automatic logic [62:0] pack3(int x, int y, int z);
      logic [20:0] a, b, c;
      a = x[20:0];
      b = y[20:0];
      c = z[20:0];
      return {c, b, a};
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 65536 * 8)) - 65536 * 4);
      endcase
   endfunction

   task automatic drain();
      while (eye_queue.size() > 0 || req_tvalid || plane_queue.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [62:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      surface[idx] = val;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic write_surface(logic [62:0] c, logic [62:0] r, logic [62:0] f,
                                logic [62:0] u);
      drain();
      write_reg(2'(rfp_pkg::REG_CENTER), c);
      write_reg(2'(rfp_pkg::REG_RIGHT), r);
      write_reg(2'(rfp_pkg::REG_FRONT), f);
      write_reg(2'(rfp_pkg::REG_UP), u);
   endtask

   task automatic queue_directed();
      eye_queue.push_back(96'h0);
      eye_queue.push_back({3{32'h7FFF_FFFF}});
      eye_queue.push_back({3{32'h8000_0000}});
      eye_queue.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001});
      eye_queue.push_back({32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000});
      eye_queue.push_back({32'hFFFF_FFFF, 32'h0003_0000, 32'hFFFF_FFFF});
   endtask

   initial begin
      logic [62:0] rr [4];
      for (int i = 0; i < rfp_pkg::NUM_REGS; i++) surface[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at reset: every vector zero, so degenerate
      queue_directed();
      drain();

      write_surface(pack3(0, 0, 0), pack3(1024, 0, 0), pack3(0, 0, 1024), pack3(0, 1024, 0));
      queue_directed();
      drain();

      write_surface(pack3(-1048576, -1048576, -1048576), pack3(-1048576, -1048576, -1048576),
                    pack3(-1048576, -1048576, -1048576), pack3(-1048576, -1048576, -1048576));
      queue_directed();
      drain();

      write_surface(pack3(1048575, 1048575, 1048575), pack3(1048575, 0, -1048576),
                    pack3(0, 1, 0), pack3(1048575, 1048575, 1048575));
      queue_directed();
      drain();

      // only up zero, then only right zero
      write_surface(pack3(512, -300, 7), pack3(0, 2048, 0), pack3(100, 0, 0), pack3(0, 0, 0));
      queue_directed();
      drain();
      write_surface({63{1'b1}}, pack3(0, 0, 0), pack3(3, -5, 9), pack3(1, 2, 3));
      queue_directed();
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < 4; i++)
            rr[i] = {$urandom(), $urandom()};
         if (ph % 2 == 1) rr[rfp_pkg::REG_UP] = pack3($urandom_range(0, 4096) - 2048,
                                                      $urandom_range(0, 4096) - 2048, 1024);
         write_surface(rr[0], rr[1], rr[2], rr[3]);
         case (ph / 2)
            0: begin send_pct = 33; recv_pct = 69; end
            1: begin send_pct = 69; recv_pct = 33; end
            default: begin send_pct = 0; recv_pct = 0; end
         endcase
         for (int i = 0; i < 65; i++)
            eye_queue.push_back({rand_coord(), rand_coord(), rand_coord()});
         if (ph == 2) begin
            stall_req = 1;
         end
         if (ph == 4) begin
            repeat (150) @(posedge clock);
            send_hold = 1;
            while (req_tvalid || plane_queue.size() > 0) @(posedge clock);
            send_hold = 0;
         end
      end
      drain();
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("reflection_frustum_planes_test: clean");
      end else begin
         $display("reflection_frustum_planes_test: errors");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("reflection_frustum_planes_test: errors");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/rfp_pkg.sv
hw/rtl/rfp_setup.sv
hw/rtl/rfp_front.sv
hw/rtl/rfp_back.sv
hw/rtl/rfp_emit.sv
hw/rtl/reflection_frustum_planes.sv
verif/reflection_frustum_planes_test.sv
